[hdl/plp_pkg.sv]
// Shared constants, types and saturation helper for the landmark projection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package plp_pkg;

  localparam int CoordW   = 32;          // coordinate width
  localparam int FracB    = 16;          // coordinate fraction bits
  localparam int QuatW    = 16;          // quaternion component width, Q2.14
  localparam int NormW    = 24;          // normalized point width, Q8.16
  localparam int RegW     = 48;          // widest config register
  localparam int FocW     = 32;          // focal / center register width
  localparam int IdxW     = 3;           // config index width
  localparam int DivSteps = NormW;       // quotient bits produced by the divider
  localparam int DivLat   = DivSteps + 3;

  localparam int InW  = 4 * QuatW + 6 * CoordW;                         // 256
  localparam int OutRaw = 8 * CoordW + 2 * NormW + 2;                   // 306
  localparam int OutW = ((OutRaw + 7) / 8) * 8;                         // 312

  localparam longint CoordMax = (64'sd1 <<< (CoordW - 1)) - 64'sd1;
  localparam longint CoordMin = -CoordMax - 64'sd1;

  typedef enum logic [IdxW-1:0] {
    RegRow0   = 3'd0,
    RegRow1   = 3'd1,
    RegRow2   = 3'd2,
    RegOffset = 3'd3,
    RegFocX   = 3'd4,
    RegFocY   = 3'd5,
    RegCtrX   = 3'd6,
    RegCtrY   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StZero = 2'd1,
    StSat  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CoordW-1:0] v;
    logic                     ov;
  } sat_t;

  // item data carried alongside the divider
  typedef struct packed {
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic                     ov;
  } side_t;

  function automatic sat_t sat_coord(input logic signed [63:0] x);
    sat_t r;
    if (x > CoordMax) begin
      r.v  = CoordW'(CoordMax);
      r.ov = 1'b1;
    end else if (x < CoordMin) begin
      r.v  = CoordW'(CoordMin);
      r.ov = 1'b1;
    end else begin
      r.v  = CoordW'(x);
      r.ov = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/pinhole_landmark_projection.sv]
// Top level: pose/landmark to body, camera, normalized and pixel coordinates.
`timescale 1ns / 1ps
`default_nettype none
//  channel  | dir | handshake         | payload
//  s_axis   | in  | s_tvalid/s_tready | s_tdata 256b: pose and landmark
//  m_axis   | out | m_tvalid/m_tready | m_tdata 312b: body, camera, norm, pixel, status
//  config   | in  | wr_en             | wr_index 3b, wr_data 48b
//
// Fully pipelined: one item per cycle unless the output stalls.
// The 24-step restoring divider sets the depth.
// rst clears the valid bits and loads register reset values.
// When the output holds an item that is not taken, the whole pipeline holds.
module pinhole_landmark_projection (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // quat_w, quat_x, quat_y, quat_z, body_pos_x/y/z, landmark_x/y/z
  input  wire logic [plp_pkg::InW-1:0]         s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // body_pt_x/y/z, cam_pt_x/y/z, norm_u, norm_v, pixel_u, pixel_v, status, zero pad
  output logic [plp_pkg::OutW-1:0]             m_tdata,
  input  wire logic                            wr_en,
  input  wire logic [plp_pkg::IdxW-1:0]        wr_index,
  input  wire logic [plp_pkg::RegW-1:0]        wr_data
);

  localparam int CW = plp_pkg::CoordW;
  localparam int QW = plp_pkg::QuatW;
  localparam int NW = plp_pkg::NormW;
  localparam int FW = plp_pkg::FocW;
  localparam int DL = plp_pkg::DivLat;

  // config registers
  logic [plp_pkg::RegW-1:0] row [3];
  logic [plp_pkg::RegW-1:0] offset;
  logic [FW-1:0] focal_x, focal_y, center_x, center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]   <= 48'd16384;
      row[1]   <= 48'd1073741824;
      row[2]   <= 48'd70368744177664;
      offset   <= '0;
      focal_x  <= 32'd65536;
      focal_y  <= 32'd65536;
      center_x <= '0;
      center_y <= '0;
    end else if (wr_en) begin
      unique case (plp_pkg::reg_idx_t'(wr_index))
        plp_pkg::RegRow0:   row[0]   <= wr_data;
        plp_pkg::RegRow1:   row[1]   <= wr_data;
        plp_pkg::RegRow2:   row[2]   <= wr_data;
        plp_pkg::RegOffset: offset   <= wr_data;
        plp_pkg::RegFocX:   focal_x  <= wr_data[FW-1:0];
        plp_pkg::RegFocY:   focal_y  <= wr_data[FW-1:0];
        plp_pkg::RegCtrX:   center_x <= wr_data[FW-1:0];
        plp_pkg::RegCtrY:   center_y <= wr_data[FW-1:0];
        default: ;
      endcase
    end
  end

  logic ce;
  logic vout;
  assign ce       = !vout || m_tready;
  assign s_tready = ce;

  // input unpack
  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [CW-1:0] pos [3];
  logic signed [CW-1:0] lmk [3];
  always_comb begin
    qw = $signed(s_tdata[0*QW +: QW]);
    qx = $signed(s_tdata[1*QW +: QW]);
    qy = $signed(s_tdata[2*QW +: QW]);
    qz = $signed(s_tdata[3*QW +: QW]);
    for (int i = 0; i < 3; i++) begin
      pos[i] = $signed(s_tdata[4*QW + i*CW +: CW]);
      lmk[i] = $signed(s_tdata[4*QW + (3+i)*CW +: CW]);
    end
  end

  // stage 1: quaternion products, world offset
  logic v1;
  logic signed [2*QW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [CW:0] d1 [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      xx <= qx * qx;  yy <= qy * qy;  zz <= qz * qz;
      xy <= qx * qy;  xz <= qx * qz;  yz <= qy * qz;
      wx <= qw * qx;  wy <= qw * qy;  wz <= qw * qz;
      for (int i = 0; i < 3; i++) d1[i] <= (CW+1)'(lmk[i]) - (CW+1)'(pos[i]);
    end
  end

  // stage 2: rotation matrix in Q.28, rounded to Q.20
  localparam int MW = 35;
  localparam int RW = MW - 8;
  localparam logic signed [MW-1:0] One = MW'(64'sd1 <<< 28);
  logic signed [MW-1:0] mf [3][3];
  always_comb begin
    mf[0][0] = One - ((MW'(yy) + MW'(zz)) <<< 1);
    mf[0][1] = (MW'(xy) - MW'(wz)) <<< 1;
    mf[0][2] = (MW'(xz) + MW'(wy)) <<< 1;
    mf[1][0] = (MW'(xy) + MW'(wz)) <<< 1;
    mf[1][1] = One - ((MW'(xx) + MW'(zz)) <<< 1);
    mf[1][2] = (MW'(yz) - MW'(wx)) <<< 1;
    mf[2][0] = (MW'(xz) - MW'(wy)) <<< 1;
    mf[2][1] = (MW'(yz) + MW'(wx)) <<< 1;
    mf[2][2] = One - ((MW'(xx) + MW'(yy)) <<< 1);
  end

  logic v2;
  logic signed [RW-1:0] m2 [3][3];
  logic signed [CW:0]   d2 [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        d2[i] <= d1[i];
        for (int j = 0; j < 3; j++) m2[i][j] <= RW'((mf[i][j] + MW'(128)) >>> 8);
      end
    end
  end

  // stage 3: transpose rotation products
  localparam int P3W = RW + CW + 1;
  logic v3;
  logic signed [P3W-1:0] p3 [3][3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) p3[i][j] <= m2[j][i] * d2[j];
    end
  end

  // stage 4: sum, round, clamp to body point
  localparam int A4W = P3W + 2;
  logic signed [A4W-1:0] acc4 [3];
  plp_pkg::sat_t sat4 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc4[i] = A4W'(p3[i][0]) + A4W'(p3[i][1]) + A4W'(p3[i][2]);
      sat4[i] = plp_pkg::sat_coord(64'((acc4[i] + A4W'(64'sd1 <<< 19)) >>> 20));
    end
  end

  logic v4, ov4;
  logic signed [CW-1:0] body4 [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) body4[i] <= sat4[i].v;
      ov4 <= sat4[0].ov | sat4[1].ov | sat4[2].ov;
    end
  end

  // stage 5: subtract camera offset, extrinsic products
  localparam int P5W = QW + CW + 1;
  logic signed [CW:0] e5 [3];
  always_comb begin
    for (int j = 0; j < 3; j++)
      e5[j] = (CW+1)'(body4[j])
            - ((CW+1)'($signed(offset[16*j +: 16])) <<< (plp_pkg::FracB - 8));
  end

  logic v5, ov5;
  logic signed [P5W-1:0] p5 [3][3];
  logic signed [CW-1:0]  body5 [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        body5[i] <= body4[i];
        for (int j = 0; j < 3; j++) p5[i][j] <= $signed(row[j][16*i +: 16]) * e5[j];
      end
      ov5 <= ov4;
    end
  end

  // stage 6: sum, round, clamp to camera point
  localparam int A6W = P5W + 2;
  logic signed [A6W-1:0] acc6 [3];
  plp_pkg::sat_t sat6 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc6[i] = A6W'(p5[i][0]) + A6W'(p5[i][1]) + A6W'(p5[i][2]);
      sat6[i] = plp_pkg::sat_coord(64'((acc6[i] + A6W'(64'sd1 <<< 13)) >>> 14));
    end
  end

  logic v6;
  plp_pkg::side_t side6;
  always_ff @(posedge clk) begin
    if (ce) begin
      side6.bx <= body5[0];
      side6.by <= body5[1];
      side6.bz <= body5[2];
      side6.cx <= sat6[0].v;
      side6.cy <= sat6[1].v;
      side6.cz <= sat6[2].v;
      side6.ov <= ov5 | sat6[0].ov | sat6[1].ov | sat6[2].ov;
    end
  end

  // divide by depth
  logic signed [NW-1:0] nu_d, nv_d;
  logic ovu_d, ovv_d;

  plp_div u_div_u (
    .clk (clk), .ce (ce), .num (side6.cx), .den (side6.cz), .quo (nu_d), .ovf (ovu_d)
  );
  plp_div u_div_v (
    .clk (clk), .ce (ce), .num (side6.cy), .den (side6.cz), .quo (nv_d), .ovf (ovv_d)
  );

  logic           vd   [DL];
  plp_pkg::side_t sd   [DL];
  always_ff @(posedge clk) begin
    if (ce) begin
      sd[0] <= side6;
      for (int k = 1; k < DL; k++) sd[k] <= sd[k-1];
    end
  end

  // stage P1: focal products
  localparam int PPW = FW + 1 + NW;
  logic vp1;
  plp_pkg::side_t sp1;
  logic signed [NW-1:0]  nu1, nv1;
  logic signed [PPW-1:0] pu1, pv1;
  logic                  ovn1;
  always_ff @(posedge clk) begin
    if (ce) begin
      sp1  <= sd[DL-1];
      nu1  <= nu_d;
      nv1  <= nv_d;
      ovn1 <= ovu_d | ovv_d;
      pu1  <= $signed({1'b0, focal_x}) * nu_d;
      pv1  <= $signed({1'b0, focal_y}) * nv_d;
    end
  end

  // stage P2: round, add principal point, clamp, status
  localparam int SH = 32 - plp_pkg::FracB;
  localparam int XW = PPW + 2;
  plp_pkg::sat_t satu, satv;
  logic zero_d;
  always_comb begin
    satu = plp_pkg::sat_coord(64'(((XW'(pu1) + XW'(64'sd1 <<< (SH-1))) >>> SH)
                                   + XW'($signed({1'b0, center_x}))));
    satv = plp_pkg::sat_coord(64'(((XW'(pv1) + XW'(64'sd1 <<< (SH-1))) >>> SH)
                                   + XW'($signed({1'b0, center_y}))));
    zero_d = (sp1.cz == '0);
  end

  plp_pkg::side_t  so;
  logic signed [NW-1:0] nuo, nvo;
  logic signed [CW-1:0] puo, pvo;
  plp_pkg::status_t     sto;
  always_ff @(posedge clk) begin
    if (ce) begin
      so <= sp1;
      if (zero_d) begin
        nuo <= '0;
        nvo <= '0;
        puo <= '0;
        pvo <= '0;
        sto <= plp_pkg::StZero;
      end else begin
        nuo <= nu1;
        nvo <= nv1;
        puo <= satu.v;
        pvo <= satv.v;
        sto <= (sp1.ov | ovn1 | satu.ov | satv.ov) ? plp_pkg::StSat : plp_pkg::StOk;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      for (int k = 0; k < DL; k++) vd[k] <= 1'b0;
      vp1  <= 1'b0;
      vout <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      vd[0] <= v6;
      for (int k = 1; k < DL; k++) vd[k] <= vd[k-1];
      vp1  <= vd[DL-1];
      vout <= vp1;
    end
  end

  assign m_tvalid = vout;
  assign m_tdata  = {(plp_pkg::OutW - plp_pkg::OutRaw)'(0), sto, pvo, puo, nvo, nuo,
                     so.cz, so.cy, so.cx, so.bz, so.by, so.bx};

  // checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
      !ce |=> $stable(vout) && $stable(vp1) && $stable(v1))
    else $error("pipeline moved during stall");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
      vout |-> ((so.cz == '0) == (sto == plp_pkg::StZero)))
    else $error("zero depth flag mismatch");

  a_zero_pix: assert property (@(posedge clk) disable iff (rst)
      vout && (sto == plp_pkg::StZero) |-> (puo == '0) && (pvo == '0) && (nuo == '0))
    else $error("zero depth result not cleared");

endmodule
`default_nettype wire

[hdl/plp_div.sv]
// Pipelined restoring divider: round(num * 2^16 / den), ties away from zero, saturated to Q8.16.
`timescale 1ns / 1ps
`default_nettype none
module plp_div (
  input  wire logic                                clk,
  input  wire logic                                ce,
  input  wire logic signed [plp_pkg::CoordW-1:0]   num,
  input  wire logic signed [plp_pkg::CoordW-1:0]   den,
  output logic signed [plp_pkg::NormW-1:0]         quo,
  output logic                                     ovf
);

  localparam int CW = plp_pkg::CoordW;
  localparam int NS = plp_pkg::DivSteps;
  localparam int NW = CW + 18;    // 2*|num|*2^16 + |den|
  localparam int DW = CW + 2;     // 2*|den|, also remainder width
  localparam int AW = CW + 1;

  // stage A: magnitudes and rounding numerator
  logic signed [AW-1:0] nx, dx;
  logic        [AW-1:0] an, ad;
  logic        [NW-1:0] a_n;
  logic        [DW-1:0] a_d;
  logic                 a_neg;

  always_comb begin
    nx = AW'(num);
    dx = AW'(den);
    an = nx[AW-1] ? AW'(-nx) : AW'(nx);
    ad = dx[AW-1] ? AW'(-dx) : AW'(dx);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_n   <= {an, 17'b0} + NW'(ad);
      a_d   <= {1'b0, ad} << 1;
      a_neg <= num[CW-1] ^ den[CW-1];
    end
  end

  // stage B plus one stage per quotient bit
  logic [DW-1:0] rem_s [NS+1];
  logic [NS-1:0] low_s [NS+1];
  logic [NS-1:0] q_s   [NS+1];
  logic [DW-1:0] d_s   [NS+1];
  logic          neg_s [NS+1];
  logic          big_s [NS+1];

  logic [DW-1:0] rem_n [NS];
  logic          bit_n [NS];
  logic [DW:0]   t_n   [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      t_n[k] = {rem_s[k], low_s[k][NS-1-k]};
      bit_n[k] = (t_n[k] >= {1'b0, d_s[k]});
      rem_n[k] = bit_n[k] ? DW'(t_n[k] - {1'b0, d_s[k]}) : DW'(t_n[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      big_s[0] <= ((DW + NS)'(a_n) >= {a_d, NS'(0)});
      rem_s[0] <= DW'(a_n[NW-1:NS]);
      low_s[0] <= a_n[NS-1:0];
      q_s[0]   <= '0;
      d_s[0]   <= a_d;
      neg_s[0] <= a_neg;
      for (int k = 0; k < NS; k++) begin
        rem_s[k+1] <= rem_n[k];
        low_s[k+1] <= low_s[k];
        q_s[k+1]   <= {q_s[k][NS-2:0], bit_n[k]};
        d_s[k+1]   <= d_s[k];
        neg_s[k+1] <= neg_s[k];
        big_s[k+1] <= big_s[k];
      end
    end
  end

  // final stage: sign and clamp
  logic [NS-1:0] mag;
  assign mag = q_s[NS];

  always_ff @(posedge clk) begin
    if (ce) begin
      if (neg_s[NS]) begin
        if (big_s[NS] || (mag > {1'b1, (NS-1)'(0)})) begin
          quo <= {1'b1, (NS-1)'(0)};
          ovf <= 1'b1;
        end else begin
          quo <= $signed(NS'(-mag));
          ovf <= 1'b0;
        end
      end else begin
        if (big_s[NS] || mag[NS-1]) begin
          quo <= {1'b0, {(NS-1){1'b1}}};
          ovf <= 1'b1;
        end else begin
          quo <= $signed(mag);
          ovf <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[tb/tb_pinhole_landmark_projection.sv]
// Testbench for the pinhole landmark projection pipeline: scoreboard against a projection model.
`timescale 1ns / 1ps
`default_nettype none
module tb_pinhole_landmark_projection;

  typedef struct {
    longint bx, by, bz, cx, cy, cz, nu, nv, pu, pv;
    int st;
  } proj_t;

  class proj_board;
    logic [plp_pkg::RegW-1:0] regs [8];
    proj_t pending [$];
    int errors;

    function void reset_regs();
      regs[plp_pkg::RegRow0] = 48'd16384;
      regs[plp_pkg::RegRow1] = 48'd1073741824;
      regs[plp_pkg::RegRow2] = 48'd70368744177664;
      regs[plp_pkg::RegOffset] = '0;
      regs[plp_pkg::RegFocX] = 48'd65536;
      regs[plp_pkg::RegFocY] = 48'd65536;
      regs[plp_pkg::RegCtrX] = '0;
      regs[plp_pkg::RegCtrY] = '0;
    endfunction

    function void write_reg(int idx, logic [plp_pkg::RegW-1:0] v);
      regs[idx] = (idx >= plp_pkg::RegFocX) ? {16'd0, v[31:0]} : v;
    endfunction

    static function longint rnd_shr(longint v, int s);
      longint t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
    endfunction

    static function longint sat(longint v, int w, ref bit ov);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin ov = 1; return hi; end
      if (v < lo) begin ov = 1; return lo; end
      return v;
    endfunction

    static function longint div_near(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function void note_input(logic [plp_pkg::InW-1:0] din);
      longint q[4], m[3][3], dv[3], body[3], e[3], cam[3], rb[3][3], acc;
      longint one;
      proj_t r;
      bit ov;
      one = 64'sd1 <<< 28;
      ov = 0;
      for (int k = 0; k < 4; k++) q[k] = longint'($signed(din[16*k +: 16]));
      // q = {w, x, y, z}
      m[0][0] = one - 2 * (q[2]*q[2] + q[3]*q[3]);
      m[0][1] = 2 * (q[1]*q[2] - q[0]*q[3]);
      m[0][2] = 2 * (q[1]*q[3] + q[0]*q[2]);
      m[1][0] = 2 * (q[1]*q[2] + q[0]*q[3]);
      m[1][1] = one - 2 * (q[1]*q[1] + q[3]*q[3]);
      m[1][2] = 2 * (q[2]*q[3] - q[0]*q[1]);
      m[2][0] = 2 * (q[1]*q[3] - q[0]*q[2]);
      m[2][1] = 2 * (q[2]*q[3] + q[0]*q[1]);
      m[2][2] = one - 2 * (q[1]*q[1] + q[2]*q[2]);
      for (int i = 0; i < 3; i++) begin
        dv[i] = longint'($signed(din[64 + 96 + 32*i +: 32]))
              - longint'($signed(din[64 + 32*i +: 32]));
        for (int j = 0; j < 3; j++) begin
          m[i][j] = rnd_shr(m[i][j], 8);
          rb[i][j] = longint'($signed(regs[i][16*j +: 16]));
        end
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += m[j][i] * dv[j];
        body[i] = sat(rnd_shr(acc, 20), plp_pkg::CoordW, ov);
      end
      for (int i = 0; i < 3; i++)
        e[i] = body[i] - longint'($signed(regs[plp_pkg::RegOffset][16*i +: 16])) * 256;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += rb[j][i] * e[j];
        cam[i] = sat(rnd_shr(acc, 14), plp_pkg::CoordW, ov);
      end
      r.bx = body[0]; r.by = body[1]; r.bz = body[2];
      r.cx = cam[0]; r.cy = cam[1]; r.cz = cam[2];
      r.nu = 0; r.nv = 0; r.pu = 0; r.pv = 0;
      if (cam[2] == 0) r.st = plp_pkg::StZero;
      else begin
        r.nu = sat(div_near(cam[0] * 65536, cam[2]), plp_pkg::NormW, ov);
        r.nv = sat(div_near(cam[1] * 65536, cam[2]), plp_pkg::NormW, ov);
        r.pu = sat(rnd_shr(longint'(regs[plp_pkg::RegFocX][31:0]) * r.nu, 16)
                   + longint'(regs[plp_pkg::RegCtrX][31:0]), plp_pkg::CoordW, ov);
        r.pv = sat(rnd_shr(longint'(regs[plp_pkg::RegFocY][31:0]) * r.nv, 16)
                   + longint'(regs[plp_pkg::RegCtrY][31:0]), plp_pkg::CoordW, ov);
        r.st = ov ? plp_pkg::StSat : plp_pkg::StOk;
      end
      pending.push_back(r);
    endfunction

    function void mismatch(string f, longint exp_v, longint act_v);
      if (errors < 10)
        $display("mismatch %s: expected %0d got %0d", f, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(logic [plp_pkg::OutW-1:0] d);
      proj_t r;
      if (pending.size() == 0) begin
        if (errors < 10) $display("unexpected item at output");
        errors++;
        return;
      end
      r = pending.pop_front();
      if (longint'($signed(d[0 +: 32])) != r.bx) mismatch("body_x", r.bx, $signed(d[0 +: 32]));
      if (longint'($signed(d[32 +: 32])) != r.by) mismatch("body_y", r.by, $signed(d[32 +: 32]));
      if (longint'($signed(d[64 +: 32])) != r.bz) mismatch("body_z", r.bz, $signed(d[64 +: 32]));
      if (longint'($signed(d[96 +: 32])) != r.cx) mismatch("cam_x", r.cx, $signed(d[96 +: 32]));
      if (longint'($signed(d[128 +: 32])) != r.cy) mismatch("cam_y", r.cy, $signed(d[128 +: 32]));
      if (longint'($signed(d[160 +: 32])) != r.cz) mismatch("cam_z", r.cz, $signed(d[160 +: 32]));
      if (longint'($signed(d[192 +: 24])) != r.nu) mismatch("norm_u", r.nu, $signed(d[192 +: 24]));
      if (longint'($signed(d[216 +: 24])) != r.nv) mismatch("norm_v", r.nv, $signed(d[216 +: 24]));
      if (longint'($signed(d[240 +: 32])) != r.pu) mismatch("pixel_u", r.pu, $signed(d[240 +: 32]));
      if (longint'($signed(d[272 +: 32])) != r.pv) mismatch("pixel_v", r.pv, $signed(d[272 +: 32]));
      if (int'(d[304 +: 2]) != r.st) mismatch("status", r.st, d[304 +: 2]);
      if (d[plp_pkg::OutW-1:306] != '0) mismatch("pad", 0, d[plp_pkg::OutW-1:306]);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, wr_en = 0;
  logic s_tready, m_tvalid;
  logic [plp_pkg::InW-1:0] s_tdata = '0;  // quat w,x,y,z, body_pos x,y,z, landmark x,y,z
  logic [plp_pkg::OutW-1:0] m_tdata;      // body x,y,z, cam x,y,z, norm u,v, pixel u,v, status, pad
  logic [plp_pkg::IdxW-1:0] wr_index = '0;
  logic [plp_pkg::RegW-1:0] wr_data = '0;
  int send_idle = 0, recv_stall = 0;
  proj_board board;

  pinhole_landmark_projection u_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data));

  always begin #5 clk = 1; #5 clk = 0; end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // output side: random stall, check accepted results
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // tvalid stays high between items; it drops only for sender idling or drain
  task automatic send_item(logic [plp_pkg::InW-1:0] d);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(d);
  endtask

  // wr_en is left high; the caller drops it after the last write
  task automatic write_cfg(plp_pkg::reg_idx_t idx, logic [plp_pkg::RegW-1:0] v);
    wr_en <= 1; wr_index <= idx; wr_data <= v;
    @(posedge clk);
    board.write_reg(idx, v);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(3);
      2: return 32'h7fff_ffff - $urandom_range(3);
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  function automatic logic [plp_pkg::InW-1:0] rnd_item();
    logic [plp_pkg::InW-1:0] d;
    int a;
    for (int k = 0; k < 4; k++) d[16*k +: 16] = $urandom;
    if ($urandom_range(3) != 0) begin
      // near-unit quaternions for realistic poses
      a = $urandom_range(3);
      for (int k = 0; k < 4; k++)
        d[16*k +: 16] = 16'($signed($urandom_range(6000)) - 3000);
      d[16*a +: 16] = ($urandom_range(1)) ? 16'sd16000 : -16'sd16000;
    end
    for (int k = 0; k < 6; k++) d[64 + 32*k +: 32] = rnd_coord();
    return d;
  endfunction

  function automatic logic [plp_pkg::RegW-1:0] rot_row(int col, bit neg);
    logic [plp_pkg::RegW-1:0] v;
    v = '0;
    v[16*col +: 16] = neg ? -16'sd16384 : 16'sd16384;
    return v;
  endfunction

  initial begin
    logic [plp_pkg::InW-1:0] d;
    int idle_mode [4][2] = '{'{0, 0}, '{77, 0}, '{0, 77}, '{7, 7}};
    board = new();
    board.reset_regs();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed items at reset config
    d = '0; d[15:0] = 16384; d[64+160 +: 32] = 32'h0001_0000;
    send_item(d);                                  // ahead on z, identity
    d[64+160 +: 32] = '0; send_item(d);            // zero depth
    d[64+96 +: 32] = 32'h0000_0001; d[64+160 +: 32] = 32'h0000_0001;
    send_item(d);                                  // tiny depth, unit norm u
    d = '1; send_item(d);
    d = '0; send_item(d);
    d = {6{32'h7fff_ffff}}; d[63:0] = {4{16'h8000}}; d[64 +: 96] = {3{32'h8000_0000}};
    send_item(d);                                  // range overflow of d
    d[63:0] = {4{16'h7fff}}; send_item(d);         // non-unit quaternion
    d = '0; d[15:0] = 16384; d[64+160 +: 32] = -32'sh0002_0000;
    d[64+96 +: 32] = 32'h0000_8000;
    send_item(d);                                  // negative depth
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle = idle_mode[ph % 4][0];
      recv_stall = idle_mode[ph % 4][1];
      case (ph)
        0: ;
        1: begin
          write_cfg(plp_pkg::RegFocX, 32'hffff_ffff); write_cfg(plp_pkg::RegFocY, 32'd1);
          write_cfg(plp_pkg::RegCtrX, 32'hffff_ffff); write_cfg(plp_pkg::RegCtrY, 32'd0);
        end
        2: begin
          // axes permuted: camera z along body x
          write_cfg(plp_pkg::RegRow0, rot_row(2, 0));
          write_cfg(plp_pkg::RegRow1, rot_row(0, 1));
          write_cfg(plp_pkg::RegRow2, rot_row(1, 1));
          write_cfg(plp_pkg::RegOffset, {16'h0100, 16'h8000, 16'h7fff});
          write_cfg(plp_pkg::RegFocX, 32'h01f4_0000);
          write_cfg(plp_pkg::RegFocY, 32'h01f4_0000);
          write_cfg(plp_pkg::RegCtrX, 32'h0140_0000);
          write_cfg(plp_pkg::RegCtrY, 32'h00f0_0000);
        end
        3, 5: begin
          for (int k = 0; k < 4; k++)
            write_cfg(plp_pkg::reg_idx_t'(k), {$urandom, $urandom});
          for (int k = 4; k < 8; k++) write_cfg(plp_pkg::reg_idx_t'(k), $urandom);
        end
        4: begin
          write_cfg(plp_pkg::RegRow0, '1); write_cfg(plp_pkg::RegRow1, {3{16'h8000}});
          write_cfg(plp_pkg::RegRow2, {3{16'h7fff}}); write_cfg(plp_pkg::RegOffset, '1);
          write_cfg(plp_pkg::RegCtrX, 32'h0); write_cfg(plp_pkg::RegCtrY, 32'hffff_ffff);
        end
        default: begin
          board.reset_regs();
          for (int k = 0; k < 8; k++)
            write_cfg(plp_pkg::reg_idx_t'(k), board.regs[k]);
          write_cfg(plp_pkg::RegOffset, {16'h0000, 16'hff00, 16'h0080});
        end
      endcase
      wr_en <= 0;
      for (int n = 0; n < 50; n++) begin
        send_item(rnd_item());
        if ($urandom_range(9) == 0) begin
          // back-to-back stretch, no sender gaps
          send_idle = 0;
          repeat (10) send_item(rnd_item());
          send_idle = idle_mode[ph % 4][0];
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
hdl/plp_pkg.sv
hdl/plp_div.sv
hdl/pinhole_landmark_projection.sv
tb/tb_pinhole_landmark_projection.sv
